// ===== hw/rtl/bdl_pkg.sv =====
// bdl_pkg: shared types, command codes and helpers of the bucketed digest lookup
// used by bdl_ctrl, bdl_datapath and bucketed_digest_lookup; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdl_pkg;

  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int CNT_W = 13;            // bucket base and size width
  localparam int POS_W = CNT_W + 1;     // base plus offset inside a bucket
  localparam int KEY_W = 256;
  localparam int NUM_BYTES = KEY_W / 8;
  localparam int NUM_WORDS = 4;
  localparam int WORD_W = 64;
  localparam logic [5:0] DEF_DIGEST_BYTES = 6'd16;

  typedef enum logic [1:0] {
    CMD_LOAD_ENTRY = 2'd0,
    CMD_SET_BUCKET = 2'd1,
    CMD_LOOKUP     = 2'd2,
    CMD_NOP        = 2'd3
  } bdl_cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] entry_index;
    logic [7:0]  bucket_select;
    logic [12:0] bucket_start;
    logic [12:0] bucket_size;
    logic [63:0] digest_w0;
    logic [63:0] digest_w1;
    logic [63:0] digest_w2;
    logic [63:0] digest_w3;
    logic [15:0] candidate_tag;
  } bdl_in_t;

  typedef struct packed {
    logic        found;
    logic [11:0] match_position;
    logic [15:0] tag_out;
    logic [31:0] match_count;
  } bdl_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic bucket;
    logic probe;
    logic compare;
    logic finish;
  } bdl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic range_done;
    logic hit;
    logic below;
    logic mid_zero;
    logic out_free;
  } bdl_stat_t;

  // one enable per compared byte, bit 31 is byte 0; width clamped to 1..32
  function automatic logic [NUM_BYTES-1:0] byte_enables(input logic [5:0] nb_raw);
    logic [5:0] nb;
    nb = nb_raw;
    if (nb == 6'd0) begin
      nb = 6'd1;
    end else if (nb > 6'd32) begin
      nb = 6'd32;
    end
    return ~({NUM_BYTES{1'b1}} >> nb);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bdl_ctrl.sv =====
// bdl_ctrl: sequencer of the digest lookup (accept, bucket read, probe loop, result)
// depends on bdl_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdl_ctrl
  import bdl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic [1:0] command,
  output logic           in_ready,
  input  wire bdl_stat_t stat,
  output bdl_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_BUCKET  = 5'b00010,
    ST_PROBE   = 5'b00100,
    ST_COMPARE = 5'b01000,
    ST_FINISH  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (command == CMD_LOOKUP) ? ST_BUCKET : ST_FINISH;
        end
      end
      ST_BUCKET: begin
        state_next = stat.empty ? ST_FINISH : ST_PROBE;
      end
      ST_PROBE: begin
        state_next = stat.range_done ? ST_FINISH : ST_COMPARE;
      end
      ST_COMPARE: begin
        if (stat.hit || (!stat.below && stat.mid_zero)) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_PROBE;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ready    = (state == ST_IDLE);
  assign cmd.accept  = (state == ST_IDLE) && in_valid;
  assign cmd.bucket  = (state == ST_BUCKET);
  assign cmd.probe   = (state == ST_PROBE) && !stat.range_done;
  assign cmd.compare = (state == ST_COMPARE);
  assign cmd.finish  = (state == ST_FINISH) && stat.out_free;

  // a result is only written into a free output slot
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.out_free)
    else $error("result written while output slot busy");

  // a lookup always starts with the bucket read
  a_lookup_bucket: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && command == CMD_LOOKUP) |=> state == ST_BUCKET)
    else $error("lookup did not go to bucket read");

endmodule

`default_nettype wire

// ===== hw/rtl/bdl_datapath.sv =====
// bdl_datapath: entry and bucket memories, search bounds, digest compare, result register
// depends on bdl_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdl_datapath
  import bdl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire bdl_cmd_t cmd,
  output bdl_stat_t     stat,
  input  wire bdl_in_t  in_data,
  input  wire logic     cfg_valid,
  input  wire logic [5:0] cfg_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bdl_out_t      out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  // compared byte enables
  logic [NUM_BYTES-1:0] byte_en;
  logic [KEY_W-1:0]     key_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_en <= byte_enables(DEF_DIGEST_BYTES);
    end else if (cfg_valid) begin
      byte_en <= byte_enables(cfg_data);
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_BYTES; k++) begin
      key_mask[8*k +: 8] = {8{byte_en[k]}};
    end
  end

  // item registers
  logic [KEY_W-1:0] key_r;
  logic [15:0]      tag_r;
  logic [KEY_W-1:0] in_key;

  assign in_key = {in_data.digest_w0, in_data.digest_w1, in_data.digest_w2, in_data.digest_w3};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= in_key;
      tag_r <= in_data.candidate_tag;
    end
  end

  // entry memory
  logic [KEY_W-1:0] entry_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] ent_rd;
  logic             ent_we;
  logic [POS_W-1:0] probe_pos;

  assign ent_we = cmd.accept && (in_data.command == CMD_LOAD_ENTRY)
                  && (32'(in_data.entry_index) < DEPTH32);

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[AW'(in_data.entry_index)] <= in_key;
    end
    if (cmd.probe) begin
      ent_rd <= entry_mem[AW'(probe_pos)];
    end
  end

  // bucket memory, valid bits make unwritten buckets read as empty
  logic [2*CNT_W-1:0] bucket_mem [256];
  logic [255:0]       bucket_vld;
  logic [2*CNT_W-1:0] bk_rd;
  logic               bk_rd_vld;
  logic               bk_we;

  assign bk_we = cmd.accept && (in_data.command == CMD_SET_BUCKET);

  always_ff @(posedge clk) begin
    if (bk_we) begin
      bucket_mem[in_data.bucket_select] <= {in_data.bucket_start, in_data.bucket_size};
    end
    bk_rd <= bucket_mem[in_data.digest_w0[63:56]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_vld <= '0;
      bk_rd_vld  <= 1'b0;
    end else begin
      if (bk_we) begin
        bucket_vld[in_data.bucket_select] <= 1'b1;
      end
      bk_rd_vld <= bucket_vld[in_data.digest_w0[63:56]];
    end
  end

  // bucket clipped to the table end
  logic [CNT_W-1:0] bk_base;
  logic [CNT_W-1:0] bk_cnt;
  logic [CNT_W-1:0] bk_len;
  logic [31:0]      room;

  always_comb begin
    bk_base = bk_rd_vld ? bk_rd[2*CNT_W-1:CNT_W] : '0;
    bk_cnt  = bk_rd_vld ? bk_rd[CNT_W-1:0] : '0;
    room    = DEPTH32 - 32'(bk_base);
    if (32'(bk_base) >= DEPTH32) begin
      bk_len = '0;
    end else if (32'(bk_cnt) > room) begin
      bk_len = CNT_W'(room);
    end else begin
      bk_len = bk_cnt;
    end
  end

  // search bounds
  logic [CNT_W-1:0] lo_r, hi_r, mid_r, base_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] bound_sum;
  logic [CNT_W-1:0] mid;
  logic             found_r;

  assign bound_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = bound_sum[POS_W-1:1];
  assign probe_pos = {1'b0, base_r} + {1'b0, mid};

  // masked lexicographic compare, word 0 most significant
  logic [NUM_WORDS-1:0] w_lt, w_eq;
  logic                 hit, below;

  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      w_lt[w] = (ent_rd[KEY_W-1-WORD_W*w -: WORD_W] & key_mask[KEY_W-1-WORD_W*w -: WORD_W])
              < (key_r[KEY_W-1-WORD_W*w -: WORD_W] & key_mask[KEY_W-1-WORD_W*w -: WORD_W]);
      w_eq[w] = ((ent_rd[KEY_W-1-WORD_W*w -: WORD_W] ^ key_r[KEY_W-1-WORD_W*w -: WORD_W])
              & key_mask[KEY_W-1-WORD_W*w -: WORD_W]) == '0;
    end
    hit   = &w_eq;
    below = w_lt[0] | (w_eq[0] & w_lt[1]) | (w_eq[0] & w_eq[1] & w_lt[2])
          | (w_eq[0] & w_eq[1] & w_eq[2] & w_lt[3]);
  end

  always_ff @(posedge clk) begin
    if (cmd.bucket) begin
      base_r <= bk_base;
      lo_r   <= '0;
      hi_r   <= bk_len - CNT_W'(1);
    end
    if (cmd.probe) begin
      mid_r <= mid;
      pos_r <= probe_pos;
    end
    if (cmd.compare && !hit) begin
      if (below) begin
        lo_r <= mid_r + CNT_W'(1);
      end else if (mid_r != '0) begin
        hi_r <= mid_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_r <= 1'b0;
    end else if (cmd.accept) begin
      found_r <= 1'b0;
    end else if (cmd.compare && hit) begin
      found_r <= 1'b1;
    end
  end

  // result register and match counter
  logic [31:0] match_total;
  logic [31:0] match_total_next;

  assign match_total_next = match_total + {31'd0, found_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      match_total <= '0;
      out_valid   <= 1'b0;
    end else if (cmd.finish) begin
      match_total <= match_total_next;
      out_valid   <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.found          <= found_r;
      out_data.match_position <= found_r ? pos_r[11:0] : 12'd0;
      out_data.tag_out        <= tag_r;
      out_data.match_count    <= match_total_next;
    end
  end

  assign stat.empty      = (bk_len == '0);
  assign stat.range_done = (lo_r > hi_r);
  assign stat.hit        = hit;
  assign stat.below      = below;
  assign stat.mid_zero   = (mid_r == '0);
  assign stat.out_free   = !out_valid || out_ready;

  // the probed offset lies inside the live bounds
  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.compare |-> (mid_r >= lo_r) && (mid_r <= hi_r))
    else $error("probe offset outside search bounds");

  // a matching compare marks the item found
  a_hit_found: assert property (@(posedge clk) disable iff (rst)
    (cmd.compare && hit) |=> found_r)
    else $error("hit not recorded");

  // the match counter only moves when a result is written
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !cmd.finish |=> $stable(match_total))
    else $error("match counter moved without a result");

endmodule

`default_nettype wire

// ===== hw/rtl/bucketed_digest_lookup.sv =====
// bucketed_digest_lookup: top level, joins the sequencer and the datapath
// depends on bdl_pkg, bdl_ctrl, bdl_datapath
`timescale 1ns / 1ps
`default_nettype none

//  channel   signals                         payload
//  in        in_valid / in_ready             bdl_in_t  (command, indexes, digest, tag)
//  out       out_valid / out_ready           bdl_out_t (found, position, tag, count)
//  cfg       cfg_valid / cfg_ready           digest_bytes, 6 bits
//
//  load entry, set bucket and no-op: accept, then the finish state, then in_ready again
//  lookup: bucket read, then p probes (at most 13 for 4096 entries), then finish; a
//    probe is one entry memory read and one compare; a spent range adds a last bound check
//  reset clears the sequencer, bucket valid bits, found flag, counter and output valid;
//    entry memory is not cleared, digest width returns to 16 bytes, bucket table reads zero until written
//  a held result stalls only the final step; the next item is not taken until it is written

module bucketed_digest_lookup
  import bdl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  // item input
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bdl_in_t  in_data,
  // result output
  output logic          out_valid,
  input  wire logic     out_ready,
  output bdl_out_t      out_data,
  // digest width register
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [5:0] cfg_data
);

  bdl_cmd_t  cmd;
  bdl_stat_t stat;

  // register writes take effect in the next cycle, always taken
  assign cfg_ready = 1'b1;

  // sequencer: one item at a time, walks bucket read and probe loop
  bdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (in_data.command),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memories, bounds, compare and result register
  bdl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
